// File: hdl/mftt_pkg.sv
// Shared constants, types and field widths for the motor feedback turn tracker.
package mftt_pkg;

   localparam int MOTORS_PER_GROUP = 4;
   localparam int SLOT_COUNT       = 2 * MOTORS_PER_GROUP;
   localparam int SLOT_W           = $clog2(SLOT_COUNT);
   localparam int INDEX_W          = 2;

   localparam int ENC_W   = 16;
   localparam int SPD_W   = 16;
   localparam int CUR_W   = 16;
   localparam int TEMP_W  = 8;
   localparam int TURN_W  = 16;
   localparam int ANGLE_W = 37;
   localparam int ERR_W   = 38;

   localparam int REQ_TDATA_W = 64;
   localparam int REQ_TUSER_W = INDEX_W + 1;
   localparam int RSP_FIELD_W = ENC_W + SPD_W + CUR_W + TEMP_W + TURN_W + ANGLE_W + ERR_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W = SLOT_W;
   localparam int FRAME_W     = REQ_TDATA_W - 8;

   // turns * 8192 + encoder, signed; and its magnitude
   localparam int POS_W   = TURN_W + 14;
   localparam int MAG_W   = POS_W - 1;
   localparam int ENC_SHIFT = 13;

   // round(m * 2880 / 19) = 151*m + floor((11*m + 9) / 19)
   localparam int FRAC_MUL   = 151;
   localparam int REM_MUL    = 11;
   localparam int ROUND_BIAS = 9;
   localparam int Y_W        = 32;
   localparam int BASE_W     = 36;
   localparam int QUOT_W     = 29;

   // floor(y / 19) = (y * ceil(2^37 / 19)) >> 37 for y below 2^32
   localparam logic [32:0] RECIP    = 33'd7233629131;
   localparam int          LO_W     = 16;
   localparam logic [LO_W-1:0]  RECIP_LO = RECIP[LO_W-1:0];
   localparam logic [32-LO_W:0] RECIP_HI = RECIP[32:LO_W];
   localparam int PLO_W     = Y_W + LO_W;
   localparam int PHI_W     = Y_W + 33 - LO_W;
   localparam int PSUM_W    = PHI_W + 1;
   localparam int HI_SHIFT  = 37 - LO_W;

   localparam int STAGES  = 7;
   localparam int SCALE_STAGES = 5;

   localparam logic signed [ENC_W:0]  WRAP_HI  = 17'sd4096;
   localparam logic signed [ENC_W:0]  WRAP_LO  = -17'sd4096;
   localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;
   localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7fff;

   typedef struct packed {
      logic [SLOT_W-1:0]        slot;
      logic [ENC_W-1:0]         enc;
      logic [SPD_W-1:0]         spd;
      logic [CUR_W-1:0]         cur;
      logic [TEMP_W-1:0]        temp;
      logic signed [TURN_W-1:0] turns;
   } side_type;

endpackage

// File: hdl/mftt_scale.sv
// Pipelined scaling of signed encoder position to fixed-point output shaft angle.
module mftt_scale (
   input  logic                                 clock,
   input  logic [mftt_pkg::SCALE_STAGES-1:0]    adv,
   input  logic signed [mftt_pkg::POS_W-1:0]    pos,
   output logic signed [mftt_pkg::ANGLE_W-1:0]  angle
);

   logic signed [mftt_pkg::POS_W-1:0]   pos_ff;
   logic [mftt_pkg::POS_W-1:0]          pos_neg;
   logic [mftt_pkg::MAG_W-1:0]          mag;
   logic                                neg2_ff, neg3_ff, neg4_ff;
   logic [mftt_pkg::Y_W-1:0]            y_in, y2_ff;
   logic [mftt_pkg::BASE_W-1:0]         base_in, base2_ff, base3_ff, base4_ff;
   logic [mftt_pkg::PLO_W-1:0]          plo_in, plo3_ff;
   logic [mftt_pkg::PHI_W-1:0]          phi_in, phi3_ff;
   logic [mftt_pkg::PSUM_W-1:0]         psum;
   logic [mftt_pkg::QUOT_W-1:0]         quot_in, quot4_ff;
   logic [mftt_pkg::ANGLE_W-1:0]        mag5;
   logic signed [mftt_pkg::ANGLE_W-1:0] angle_in, angle_ff;

   always_comb begin
      pos_neg = -pos_ff;
      mag     = pos_ff[mftt_pkg::POS_W-1] ? pos_neg[mftt_pkg::MAG_W-1:0]
                                          : pos_ff[mftt_pkg::MAG_W-1:0];
      y_in    = mftt_pkg::Y_W'(mag) * mftt_pkg::Y_W'(mftt_pkg::REM_MUL)
                + mftt_pkg::Y_W'(mftt_pkg::ROUND_BIAS);
      base_in = mftt_pkg::BASE_W'(mag) * mftt_pkg::BASE_W'(mftt_pkg::FRAC_MUL);
      plo_in  = mftt_pkg::PLO_W'(y2_ff) * mftt_pkg::PLO_W'(mftt_pkg::RECIP_LO);
      phi_in  = mftt_pkg::PHI_W'(y2_ff) * mftt_pkg::PHI_W'(mftt_pkg::RECIP_HI);
      psum    = mftt_pkg::PSUM_W'(phi3_ff) + mftt_pkg::PSUM_W'(plo3_ff >> mftt_pkg::LO_W);
      quot_in = mftt_pkg::QUOT_W'(psum >> mftt_pkg::HI_SHIFT);
      mag5    = mftt_pkg::ANGLE_W'(base4_ff) + mftt_pkg::ANGLE_W'(quot4_ff);
      angle_in = neg4_ff ? -$signed(mag5) : $signed(mag5);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pos_ff <= pos;
      end
      if (adv[1]) begin
         neg2_ff  <= pos_ff[mftt_pkg::POS_W-1];
         y2_ff    <= y_in;
         base2_ff <= base_in;
      end
      if (adv[2]) begin
         neg3_ff  <= neg2_ff;
         plo3_ff  <= plo_in;
         phi3_ff  <= phi_in;
         base3_ff <= base2_ff;
      end
      if (adv[3]) begin
         neg4_ff  <= neg3_ff;
         quot4_ff <= quot_in;
         base4_ff <= base3_ff;
      end
      if (adv[4]) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

// File: hdl/motor_feedback_turn_tracker_core.sv
// Top level: per-motor multi-turn unwrap of feedback frames with angle and angle change.
//
//  channel  ports   tdata / tuser contents
//  input    req_*   tdata: frame payload; tuser: group, index
//  result   rsp_*   tdata: encoder..angle error; tuser: motor slot
//
// One beat accepted per cycle while rsp_tready is high; its result can be taken from
// the last pipeline stage once the beat has passed through all stages.
// The per-motor turn and encoder stores are read and written in the first stage,
// so a beat for the same motor may follow in the next cycle.
// The angle path is a 5-stage constant multiply pipeline, one per angle.
// rsp_tready low backs up the stages; empty stages still take beats.
// Reset clears all stage valids and all per-motor stores.
module motor_feedback_turn_tracker_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mftt_pkg::REQ_TDATA_W-1:0]    req_tdata,  // frame_payload
   input  logic [mftt_pkg::REQ_TUSER_W-1:0]    req_tuser,  // motor_group, motor_index
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // encoder_position, rotor_speed, measured_current, temperature, turn_count,
   // shaft_angle, angle_error, zero fill
   output logic [mftt_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [mftt_pkg::RSP_TUSER_W-1:0]    rsp_tuser   // motor_slot
);

   localparam int LAST = mftt_pkg::STAGES - 1;

   logic [LAST:0]                        valid_ff, valid_in, adv;
   logic                                 req_accept;
   logic [mftt_pkg::SLOT_W-1:0]          s0_slot_ff;
   logic [mftt_pkg::FRAME_W-1:0]         s0_data_ff;
   logic [mftt_pkg::ENC_W-1:0]           enc_ff [mftt_pkg::SLOT_COUNT];
   logic signed [mftt_pkg::TURN_W-1:0]   turn_ff [mftt_pkg::SLOT_COUNT];
   logic [mftt_pkg::ENC_W-1:0]           enc_rd;
   logic signed [mftt_pkg::TURN_W-1:0]   turn_rd, turn_new;
   logic signed [mftt_pkg::ENC_W:0]      delta;
   logic signed [mftt_pkg::POS_W-1:0]    pos_new, pos_prev;
   mftt_pkg::side_type                   side_in;
   mftt_pkg::side_type                   side_ff [1:LAST];
   logic signed [mftt_pkg::ANGLE_W-1:0]  angle_new, angle_prev;
   logic signed [mftt_pkg::ANGLE_W-1:0]  angle_ff;
   logic signed [mftt_pkg::ERR_W-1:0]    err_in, err_ff;

   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      adv[LAST] = valid_ff[LAST] && rsp_tready;
      for (int i = LAST - 1; i >= 0; i--) begin
         adv[i] = valid_ff[i] && (!valid_ff[i+1] || adv[i+1]);
      end
      valid_in[0] = (valid_ff[0] && !adv[0]) || req_accept;
      for (int i = 1; i <= LAST; i++) begin
         valid_in[i] = (valid_ff[i] && !adv[i]) || adv[i-1];
      end
   end

   assign req_tready = !valid_ff[0] || adv[0];

   // turn tracking on the stage-0 beat
   always_comb begin
      enc_rd  = enc_ff[s0_slot_ff];
      turn_rd = turn_ff[s0_slot_ff];
      side_in.slot  = s0_slot_ff;
      side_in.enc   = s0_data_ff[55:40];
      side_in.spd   = s0_data_ff[39:24];
      side_in.cur   = s0_data_ff[23:8];
      side_in.temp  = s0_data_ff[7:0];
      delta    = $signed({1'b0, side_in.enc}) - $signed({1'b0, enc_rd});
      turn_new = turn_rd;
      if (delta > mftt_pkg::WRAP_HI) begin
         if (turn_rd != mftt_pkg::TURN_MIN) begin
            turn_new = turn_rd - 16'sd1;
         end
      end else if (delta < mftt_pkg::WRAP_LO) begin
         if (turn_rd != mftt_pkg::TURN_MAX) begin
            turn_new = turn_rd + 16'sd1;
         end
      end
      side_in.turns = turn_new;
      pos_new  = $signed({turn_new[mftt_pkg::TURN_W-1], turn_new, mftt_pkg::ENC_SHIFT'(0)})
                 + $signed({14'b0, side_in.enc});
      pos_prev = $signed({turn_rd[mftt_pkg::TURN_W-1], turn_rd, mftt_pkg::ENC_SHIFT'(0)})
                 + $signed({14'b0, enc_rd});
   end

   mftt_scale u_scale_new (
      .clock (clock),
      .adv   (adv[mftt_pkg::SCALE_STAGES-1:0]),
      .pos   (pos_new),
      .angle (angle_new)
   );

   mftt_scale u_scale_prev (
      .clock (clock),
      .adv   (adv[mftt_pkg::SCALE_STAGES-1:0]),
      .pos   (pos_prev),
      .angle (angle_prev)
   );

   assign err_in = mftt_pkg::ERR_W'(angle_prev) - mftt_pkg::ERR_W'(angle_new);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < mftt_pkg::SLOT_COUNT; i++) begin
            enc_ff[i]  <= '0;
            turn_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         if (adv[0]) begin
            enc_ff[s0_slot_ff]  <= side_in.enc;
            turn_ff[s0_slot_ff] <= turn_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s0_slot_ff <= mftt_pkg::SLOT_W'(32'(req_tuser[0]) * mftt_pkg::MOTORS_PER_GROUP
                       + 32'(req_tuser[2:1]) % mftt_pkg::MOTORS_PER_GROUP);
         s0_data_ff <= req_tdata[mftt_pkg::REQ_TDATA_W-1:8];
      end
      if (adv[0]) begin
         side_ff[1] <= side_in;
      end
      for (int i = 1; i < LAST; i++) begin
         if (adv[i]) begin
            side_ff[i+1] <= side_ff[i];
         end
      end
      if (adv[LAST-1]) begin
         angle_ff <= angle_new;
         err_ff   <= err_in;
      end
   end

   assign rsp_tvalid = valid_ff[LAST];
   assign rsp_tuser  = side_ff[LAST].slot;
   assign rsp_tdata  = {(mftt_pkg::RSP_TDATA_W - mftt_pkg::RSP_FIELD_W)'(0),
                        err_ff, angle_ff, side_ff[LAST].turns, side_ff[LAST].temp,
                        side_ff[LAST].cur, side_ff[LAST].spd, side_ff[LAST].enc};

`ifndef NO_ASSERTIONS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> valid_ff[0])
      else $error("input stalled with stage 0 empty");

   a_beat_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones(valid_ff) == $countones($past(valid_ff))
         + $countones($past(req_accept)) - $countones($past(adv[LAST])))
      else $error("beat lost or duplicated in the pipeline");

   a_store_update: assert property (@(posedge clock) disable iff (reset)
      adv[0] |=> enc_ff[$past(s0_slot_ff)] == $past(side_in.enc)
                 && turn_ff[$past(s0_slot_ff)] == side_ff[1].turns)
      else $error("per-motor store not updated with the passed beat");
`endif

endmodule
